@@ rtl/core/ssrp_pkg.sv @@
// Shared widths, constants and controller/datapath handshake types for the servo positioner.
package ssrp_pkg;

  localparam int unsigned AngleW = 8;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned TickW  = 32;
  localparam int unsigned PulseW = 12;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_ANGLE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ANGLE = 1'b1;

  // input op codes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic load;    // take the input transaction
    logic clamp;   // clamp stored target to the window
    logic mul;     // elapsed time times speed
    logic div_fl;  // floor(p/1000), saturated
    logic div_ce;  // ceil(p/1000), saturated
    logic move;    // step the current angle
    logic emit;    // write the result register
  } ssrp_cmd_t;

  typedef struct packed {
    logic at_eq;     // clamped target equals current angle
    logic out_free;  // result register can take a new result this cycle
  } ssrp_status_t;

endpackage

@@ rtl/core/ssrp_in_if.sv @@
// Input channel: command and update transactions.
interface ssrp_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [ssrp_pkg::AngleW-1:0]       target_angle;
  logic [ssrp_pkg::SpeedW-1:0]       speed_dps;
  logic [ssrp_pkg::TickW-1:0]        now_ms;

  modport source (output valid, op, target_angle, speed_dps, now_ms, input ready);
  modport sink   (input valid, op, target_angle, speed_dps, now_ms, output ready);
endinterface

@@ rtl/core/ssrp_out_if.sv @@
// Result channel: angle, pulse width and at-target flag.
interface ssrp_out_if;
  logic                              valid;
  logic                              ready;
  logic [ssrp_pkg::AngleW-1:0]       angle;
  logic [ssrp_pkg::PulseW-1:0]       pulse_us;
  logic                              at_target;

  modport source (output valid, angle, pulse_us, at_target, input ready);
  modport sink   (input valid, angle, pulse_us, at_target, output ready);
endinterface

@@ rtl/core/ssrp_cfg_if.sv @@
// Configuration write channel.
interface ssrp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ssrp_pkg::CfgIdxW-1:0]       index;
  logic [ssrp_pkg::AngleW-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/servo_slew_rate_positioner_core.sv @@
// Servo slew-rate positioner: one channel, sequencer plus datapath.
// Usage:
//   in_i   - transactions with op: command (store target angle and speed) or
//            update (one per PWM period, moves the angle toward the target).
//   out_o  - one result per input transaction: angle, pulse width in us and
//            an at-target flag, in input order.
//   cfg_i  - writes min_angle (index 0) and max_angle (index 1); always ready.
//            It must be written only while the block is idle; the block does not enforce this.
// Sequence: a command goes from acceptance straight to the result register;
//   an update is clamped and multiplied, and if its clamped target already
//   equals the angle goes on to the result; a moving update then takes the
//   floor and ceil divides on one shared reciprocal multiplier and the move
//   before the result is written. The next transaction is accepted in the
//   cycle after the result is written, so one is finished before the next.
// The result register holds a finished result while the next transaction is
//   worked on; if the receiver still stalls, the block waits before writing.
// Reset: angle and target 90, speed 360, last tick 0, window 0..180, no
//   result pending.
module servo_slew_rate_positioner_core #(
  parameter int unsigned SPEED_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssrp_in_if.sink    in_i,
  ssrp_out_if.source out_o,
  ssrp_cfg_if.sink   cfg_i
);

  ssrp_pkg::ssrp_cmd_t    cmd;
  ssrp_pkg::ssrp_status_t status;
  logic                   ctrl_ready;

  ssrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (ctrl_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssrp_datapath #(
    .SPEED_BITS (SPEED_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

`ifndef NO_ASSERTIONS
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> ctrl_ready)
    else $error("transaction loaded while sequencer busy");

  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clamp, cmd.mul, cmd.div_fl, cmd.div_ce, cmd.move, cmd.emit}))
    else $error("more than one datapath step at once");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !ctrl_ready)
    else $error("result written from idle");
`endif

endmodule

@@ rtl/core/ssrp_ctrl.sv @@
// Sequencer for the servo positioner: steps one transaction through the datapath.
module ssrp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_op_i,
  output logic                   in_ready_o,
  input  ssrp_pkg::ssrp_status_t status_i,
  output ssrp_pkg::ssrp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL,
    ST_DIV_FL,
    ST_DIV_CE,
    ST_MOVE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.clamp  = (state_q == ST_CLAMP);
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.div_fl = (state_q == ST_DIV_FL);
    cmd_o.div_ce = (state_q == ST_DIV_CE);
    cmd_o.move   = (state_q == ST_MOVE);
    cmd_o.emit   = (state_q == ST_DONE) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == ssrp_pkg::OP_UPDATE) ? ST_CLAMP : ST_DONE;
        end
      end
      ST_CLAMP:  state_d = ST_MUL;
      // equal after clamping: only the timestamp moves
      ST_MUL:    state_d = status_i.at_eq ? ST_DONE : ST_DIV_FL;
      ST_DIV_FL: state_d = ST_DIV_CE;
      ST_DIV_CE: state_d = ST_MOVE;
      ST_MOVE:   state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/ssrp_datapath.sv @@
// Datapath: angle state, slew arithmetic, pulse mapping and the result register.
module ssrp_datapath #(
  parameter int unsigned SPEED_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ssrp_in_if.sink                in_i,
  ssrp_out_if.source             out_o,
  ssrp_cfg_if.sink               cfg_i,
  input  ssrp_pkg::ssrp_cmd_t    cmd_i,
  output ssrp_pkg::ssrp_status_t status_o
);

  localparam int unsigned AW = ssrp_pkg::AngleW;
  localparam int unsigned PW = SPEED_BITS + ssrp_pkg::TickW;
  localparam int unsigned QW = 9;   // quotient saturates at 256
  localparam int unsigned DW = 18;  // dividend width below the saturation point
  localparam int unsigned RW = 19;  // reciprocal width
  localparam int unsigned RS = 28;  // reciprocal shift
  localparam int unsigned MW = DW + RW;
  localparam logic [DW-1:0] SatLimit  = DW'(256000);   // 256 * 1000
  localparam logic [RW-1:0] Recip1000 = RW'(268436);   // ceil(2^28 / 1000)
  localparam logic [DW-1:0] CeilBias  = DW'(999);
  localparam logic [QW-1:0] QSat      = QW'(256);
  localparam logic [QW-1:0] StepLimit = QW'(180);
  localparam logic [AW-1:0] AngleMax  = AW'(180);
  localparam logic [AW-1:0] ResetAngle = AW'(90);
  localparam logic [21:0]   PulseMul  = 22'(2767160);  // 95 * ceil(2^18 / 9)
  localparam logic [ssrp_pkg::PulseW-1:0] PulseBase = ssrp_pkg::PulseW'(600);

  function automatic logic [AW-1:0] clamp_angle(input logic [AW-1:0] t,
                                                 input logic [AW-1:0] mn,
                                                 input logic [AW-1:0] mx);
    logic [AW-1:0] r;
    if (t > mx) r = mx;
    else if (t < mn) r = mn;
    else r = t;
    return r;
  endfunction

  function automatic logic [ssrp_pkg::PulseW-1:0] angle_to_pulse(input logic [AW-1:0] a);
    logic [29:0] prod;
    logic [ssrp_pkg::PulseW-1:0] r;
    prod = 30'(a) * 30'(PulseMul);
    if (a > AngleMax) r = '0;
    else r = prod[29:18] + PulseBase;
    return r;
  endfunction

  // architectural state
  logic [AW-1:0]             min_q, max_q;
  logic [AW-1:0]             target_q, current_q;
  logic [SPEED_BITS-1:0]     speed_q;
  logic [ssrp_pkg::TickW-1:0] last_tick_q;
  logic                      out_valid_q;

  // per-transaction working registers
  logic                      op_q;
  logic [ssrp_pkg::TickW-1:0] now_q;
  logic [PW-1:0]             p_q;
  logic [QW-1:0]             fl_q, ce_q;
  logic [AW-1:0]             angle_q;
  logic [ssrp_pkg::PulseW-1:0] pulse_q;
  logic                      at_target_q;

  // slew arithmetic
  logic [ssrp_pkg::TickW-1:0] elapsed;
  logic [PW-1:0]             p_d;
  logic                      p_sat;
  logic [DW-1:0]             div_opnd;
  logic [MW-1:0]             div_prod;
  logic [QW-1:0]             quot;
  logic                      up;
  logic [AW-1:0]             gap_deg, step_up, step_dn, current_d;
  logic                      reached;
  logic [AW-1:0]             ref_angle;

  assign elapsed  = now_q - last_tick_q;
  assign p_d      = PW'(speed_q) * PW'(elapsed);
  assign p_sat    = (p_q >= PW'(SatLimit));
  // one reciprocal multiplier shared by the floor and ceil passes
  assign div_opnd = cmd_i.div_ce ? (p_q[DW-1:0] + CeilBias) : p_q[DW-1:0];
  assign div_prod = MW'(div_opnd) * MW'(Recip1000);
  assign quot     = p_sat ? QSat : div_prod[MW-1:RS];

  assign up      = (target_q > current_q);
  assign gap_deg = up ? (target_q - current_q) : (current_q - target_q);
  assign reached = (fl_q >= QW'(gap_deg));

  always_comb begin
    step_up = (fl_q > StepLimit) ? StepLimit[AW-1:0] : fl_q[AW-1:0];
    step_dn = (ce_q > StepLimit) ? StepLimit[AW-1:0] : ce_q[AW-1:0];
    if (step_dn > gap_deg) step_dn = gap_deg;
    if (reached) current_d = target_q;
    else if (up) current_d = current_q + step_up;
    else current_d = current_q - step_dn;
  end

  // a command stores the raw target; compare against its clamped value
  assign ref_angle = (op_q == ssrp_pkg::OP_UPDATE) ? target_q
                                                   : clamp_angle(target_q, min_q, max_q);

  assign status_o.at_eq    = (target_q == current_q);
  assign status_o.out_free = !out_valid_q || out_o.ready;

  assign in_i.ready  = cmd_i.load;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.angle     = angle_q;
  assign out_o.pulse_us  = pulse_q;
  assign out_o.at_target = at_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= '0;
      max_q       <= AngleMax;
      target_q    <= ResetAngle;
      current_q   <= ResetAngle;
      speed_q     <= SPEED_BITS'(360);
      last_tick_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          ssrp_pkg::CFG_MIN_ANGLE: min_q <= cfg_i.data;
          ssrp_pkg::CFG_MAX_ANGLE: max_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.load && (in_i.op == ssrp_pkg::OP_COMMAND)) begin
        target_q <= in_i.target_angle;
        speed_q  <= SPEED_BITS'(in_i.speed_dps);
      end
      if (cmd_i.clamp) target_q <= clamp_angle(target_q, min_q, max_q);
      if (cmd_i.mul) last_tick_q <= now_q;
      if (cmd_i.move) current_q <= current_d;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_i.op;
      now_q <= in_i.now_ms;
    end
    if (cmd_i.mul) p_q <= p_d;
    if (cmd_i.div_fl) fl_q <= quot;
    if (cmd_i.div_ce) ce_q <= quot;
    if (cmd_i.emit) begin
      angle_q     <= current_q;
      pulse_q     <= angle_to_pulse(current_q);
      at_target_q <= (current_q == ref_angle);
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_o.ready))
    else $error("result written while result register is held");

  a_ceil_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_ce |=> (fl_q <= ce_q) && (ce_q <= fl_q + QW'(1)))
    else $error("ceil and floor quotients disagree");

  a_move_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.move && (target_q > current_q)) |=>
      (current_q <= $past(target_q)) && (current_q >= $past(current_q)))
    else $error("upward move overshot or reversed");

  a_move_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.move && (target_q < current_q)) |=>
      (current_q >= $past(target_q)) && (current_q <= $past(current_q)))
    else $error("downward move overshot or reversed");
`endif

endmodule
